>>> rtl/gca_pkg.sv
// Shared constants and the arctangent table for the great-circle azimuth core.
// No dependencies; every other RTL file uses it by scoped names.
package gca_pkg;

  // Angle width inside the datapath (Q.32 radians, signed)
  localparam int unsigned AngW = 36;
  // Sine / cosine width (Q.30, signed)
  localparam int unsigned ScW  = 33;
  // Vectoring operand width (Q.40, signed)
  localparam int unsigned VecW = 45;

  localparam logic signed [AngW-1:0] PiQ32     = 36'sd13493037705;
  localparam logic signed [AngW-1:0] HalfPiQ32 = 36'sd6746518852;
  localparam logic signed [AngW-1:0] TwoPiQ32  = 36'sd26986075410;
  localparam logic [63:0]            TwoPiU64  = 64'd26986075410;
  localparam logic signed [ScW-1:0]  GainQ30   = 33'sd652032874;

  // atan(2^-i) in Q.32, rounded to nearest
  function automatic logic signed [AngW-1:0] atan_q32(input int unsigned i);
    logic signed [AngW-1:0] r;
    case (i)
      0:  r = 36'sd3373259426;
      1:  r = 36'sd1991351318;
      2:  r = 36'sd1052175346;
      3:  r = 36'sd534100635;
      4:  r = 36'sd268086748;
      5:  r = 36'sd134174063;
      6:  r = 36'sd67103403;
      7:  r = 36'sd33553749;
      8:  r = 36'sd16777131;
      9:  r = 36'sd8388597;
      10: r = 36'sd4194303;
      11: r = 36'sd2097152;
      12: r = 36'sd1048576;
      13: r = 36'sd524288;
      14: r = 36'sd262144;
      15: r = 36'sd131072;
      16: r = 36'sd65536;
      17: r = 36'sd32768;
      18: r = 36'sd16384;
      19: r = 36'sd8192;
      20: r = 36'sd4096;
      21: r = 36'sd2048;
      22: r = 36'sd1024;
      23: r = 36'sd512;
      24: r = 36'sd256;
      25: r = 36'sd128;
      26: r = 36'sd64;
      27: r = 36'sd32;
      28: r = 36'sd16;
      29: r = 36'sd8;
      30: r = 36'sd4;
      31: r = 36'sd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/great_circle_azimuth_core.sv
// Top level of the great-circle azimuth core: chains wrap, sine/cosine, products, atan2.
// Depends on gca_pkg, gca_lon_wrap, gca_sincos, gca_prod, gca_atan2.
//
// Usage:
//   A point pair transfers in at a rising edge with start_i high and busy_o low.
//   busy_o is always low: a new pair may enter every cycle, one result per cycle.
//   Latitudes and longitudes are signed radians with ANGLE_FRAC_BITS fraction bits.
//   Each bearing_o appears for exactly one cycle with done_o high, in input order.
//   Data passes the longitude wrap, the sine/cosine pipelines, the products and
//   atan2 in that order; the longitude wrap has max(1, 30 - ANGLE_FRAC_BITS)
//   reduction stages.
//   Throughput is one pair per cycle, set by the fully unrolled CORDIC pipelines
//   (three rotation pipelines in parallel, then one vectoring pipeline).
//   Reset clears only the valid bits; no result is given for data in flight.
//   The receiver cannot stall; results leave on the cycle they are ready.
module great_circle_azimuth_core #(
  parameter int unsigned ANGLE_FRAC_BITS = 28,
  parameter int unsigned CORDIC_STAGES   = 28
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic signed [29:0] from_lat_i,
  input  logic signed [29:0] to_lat_i,
  input  logic signed [30:0] from_lon_i,
  input  logic signed [30:0] to_lon_i,
  output logic               done_o,
  output logic signed [30:0] bearing_o
);

  logic                              w_vld;
  logic signed [gca_pkg::AngW-1:0]   w_from, w_to, w_dl;
  logic                              sc_v0, sc_v1, sc_v2;
  logic signed [gca_pkg::ScW-1:0]    c0, s0, cx, sx, cd, sd;
  logic                              p_vld;
  logic signed [gca_pkg::VecW-1:0]   num, den;

  // Never held off: the whole datapath is a free-running pipeline
  assign busy_o = 1'b0;

  gca_lon_wrap #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_wrap (
    .clk_i, .rst_ni,
    .valid_i    (start_i),
    .from_lat_i, .to_lat_i, .from_lon_i, .to_lon_i,
    .valid_o    (w_vld),
    .from_ang_o (w_from),
    .to_ang_o   (w_to),
    .dlon_o     (w_dl)
  );

  // Three sine/cosine pipelines in lockstep
  gca_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_from (
    .clk_i, .rst_ni, .valid_i(w_vld), .angle_i(w_from),
    .valid_o(sc_v0), .cos_o(c0), .sin_o(s0)
  );

  gca_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_to (
    .clk_i, .rst_ni, .valid_i(w_vld), .angle_i(w_to),
    .valid_o(sc_v1), .cos_o(cx), .sin_o(sx)
  );

  gca_sincos #(.CORDIC_STAGES(CORDIC_STAGES)) u_sc_dl (
    .clk_i, .rst_ni, .valid_i(w_vld), .angle_i(w_dl),
    .valid_o(sc_v2), .cos_o(cd), .sin_o(sd)
  );

  gca_prod u_prod (
    .clk_i, .rst_ni,
    .valid_i (sc_v0 & sc_v1 & sc_v2),
    .s0_i(s0), .c0_i(c0), .sx_i(sx), .cx_i(cx), .sd_i(sd), .cd_i(cd),
    .valid_o (p_vld),
    .num_o   (num),
    .den_o   (den)
  );

  gca_atan2 #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS),
    .CORDIC_STAGES  (CORDIC_STAGES)
  ) u_atan2 (
    .clk_i, .rst_ni,
    .valid_i (p_vld),
    .y_i     (den),
    .x_i     (num),
    .valid_o (done_o),
    .angle_o (bearing_o)
  );

endmodule

>>> rtl/gca_lon_wrap.sv
// Input stage: latitude clamp, longitude difference and its reduction into (-pi, pi].
// Depends on gca_pkg.
module gca_lon_wrap #(
  parameter int unsigned ANGLE_FRAC_BITS = 28
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic signed [29:0]                 from_lat_i,
  input  logic signed [29:0]                 to_lat_i,
  input  logic signed [30:0]                 from_lon_i,
  input  logic signed [30:0]                 to_lon_i,
  output logic                               valid_o,
  output logic signed [gca_pkg::AngW-1:0]    from_ang_o,
  output logic signed [gca_pkg::AngW-1:0]    to_ang_o,
  output logic signed [gca_pkg::AngW-1:0]    dlon_o
);

  localparam int unsigned AW   = gca_pkg::AngW;
  localparam int unsigned SH   = 32 - ANGLE_FRAC_BITS;
  localparam int unsigned DLW  = 65 - ANGLE_FRAC_BITS;
  localparam int unsigned NRED = (30 > ANGLE_FRAC_BITS + 1) ? 30 - ANGLE_FRAC_BITS : 1;
  localparam logic signed [46:0] Lim =
    47'(gca_pkg::HalfPiQ32) - (47'sd1 <<< SH);
  localparam logic [DLW-1:0] PiU    = DLW'(gca_pkg::PiQ32);
  localparam logic [DLW-1:0] TwoPiU = DLW'(gca_pkg::TwoPiQ32);

  // Saturate a latitude to just inside the poles
  function automatic logic signed [AW-1:0] clamp_lat(input logic signed [29:0] raw);
    logic signed [46:0] v;
    v = 47'(raw) <<< SH;
    if (v > Lim) v = Lim;
    if (v < -Lim) v = -Lim;
    return AW'(v);
  endfunction

  function automatic logic [63:0] TwoPiU64Shift(input int unsigned k);
    return gca_pkg::TwoPiU64 << k;
  endfunction

  logic                   vld_q  [0:NRED];
  logic                   neg_q  [0:NRED];
  logic [DLW-1:0]         mag_q  [0:NRED];
  logic signed [AW-1:0]   a0_q   [0:NRED];
  logic signed [AW-1:0]   a1_q   [0:NRED];

  logic signed [31:0]     diff;
  logic signed [DLW-1:0]  dl_s;

  assign diff = 32'(from_lon_i) - 32'(to_lon_i);
  assign dl_s = DLW'(diff) <<< SH;

  // Entry stage: scale, split sign and magnitude, clamp latitudes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q[0] <= dl_s[DLW-1];
    mag_q[0] <= dl_s[DLW-1] ? DLW'(-dl_s) : DLW'(dl_s);
    a0_q[0]  <= clamp_lat(from_lat_i);
    a1_q[0]  <= clamp_lat(to_lat_i);
  end

  // Restoring reduction by 2pi * 2^k, largest multiple first
  for (genvar j = 1; j <= NRED; j++) begin : g_red
    localparam logic [DLW-1:0] Step = DLW'(TwoPiU64Shift(NRED - j));
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else begin
        vld_q[j] <= vld_q[j-1];
      end
    end
    always_ff @(posedge clk_i) begin
      neg_q[j] <= neg_q[j-1];
      mag_q[j] <= (mag_q[j-1] >= Step) ? mag_q[j-1] - Step : mag_q[j-1];
      a0_q[j]  <= a0_q[j-1];
      a1_q[j]  <= a1_q[j-1];
    end
  end

  // Signed remainder, then fold into (-pi, pi]
  logic [DLW-1:0] dl_d;
  always_comb begin
    if (!neg_q[NRED]) begin
      dl_d = (mag_q[NRED] > PiU) ? mag_q[NRED] - TwoPiU : mag_q[NRED];
    end else begin
      dl_d = (mag_q[NRED] >= PiU) ? TwoPiU - mag_q[NRED] : DLW'(-mag_q[NRED]);
    end
  end

  logic                  vo_q;
  logic signed [AW-1:0]  dl_q, f_q, t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= vld_q[NRED];
    end
  end

  always_ff @(posedge clk_i) begin
    dl_q <= AW'(signed'(dl_d));
    f_q  <= a0_q[NRED];
    t_q  <= a1_q[NRED];
  end

  assign valid_o    = vo_q;
  assign from_ang_o = f_q;
  assign to_ang_o   = t_q;
  assign dlon_o     = dl_q;

endmodule

>>> rtl/gca_sincos.sv
// Pipelined rotation CORDIC: cosine and sine (Q.30) of a Q.32 angle in (-pi, pi].
// Depends on gca_pkg.
module gca_sincos #(
  parameter int unsigned CORDIC_STAGES = 28
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic signed [gca_pkg::AngW-1:0]   angle_i,
  output logic                              valid_o,
  output logic signed [gca_pkg::ScW-1:0]    cos_o,
  output logic signed [gca_pkg::ScW-1:0]    sin_o
);

  localparam int unsigned AW = gca_pkg::AngW;
  localparam int unsigned XW = gca_pkg::ScW;
  localparam int unsigned N  = CORDIC_STAGES;

  logic                 v_q [0:N];
  logic                 n_q [0:N];
  logic signed [XW-1:0] x_q [0:N];
  logic signed [XW-1:0] y_q [0:N];
  logic signed [AW-1:0] z_q [0:N];

  // Pre-rotation by pi for angles beyond a quarter turn
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0] <= gca_pkg::GainQ30;
    y_q[0] <= '0;
    if (angle_i > gca_pkg::HalfPiQ32) begin
      z_q[0] <= angle_i - gca_pkg::PiQ32;
      n_q[0] <= 1'b1;
    end else if (angle_i < -gca_pkg::HalfPiQ32) begin
      z_q[0] <= angle_i + gca_pkg::PiQ32;
      n_q[0] <= 1'b1;
    end else begin
      z_q[0] <= angle_i;
      n_q[0] <= 1'b0;
    end
  end

  // One micro-rotation per stage
  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [AW-1:0] At = gca_pkg::atan_q32(i);
    logic signed [XW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      n_q[i+1] <= n_q[i];
      if (!z_q[i][AW-1]) begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        z_q[i+1] <= z_q[i] - At;
      end else begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        z_q[i+1] <= z_q[i] + At;
      end
    end
  end

  // Undo the pre-rotation
  logic                 vo_q;
  logic signed [XW-1:0] c_q, s_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else begin
      vo_q <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    c_q <= n_q[N] ? -x_q[N] : x_q[N];
    s_q <= n_q[N] ? -y_q[N] : y_q[N];
  end

  assign valid_o = vo_q;
  assign cos_o   = c_q;
  assign sin_o   = s_q;

endmodule

>>> rtl/gca_prod.sv
// Product stages: forms the Q.40 numerator and denominator of the bearing.
// Depends on gca_pkg.
module gca_prod (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic signed [gca_pkg::ScW-1:0]   s0_i,
  input  logic signed [gca_pkg::ScW-1:0]   c0_i,
  input  logic signed [gca_pkg::ScW-1:0]   sx_i,
  input  logic signed [gca_pkg::ScW-1:0]   cx_i,
  input  logic signed [gca_pkg::ScW-1:0]   sd_i,
  input  logic signed [gca_pkg::ScW-1:0]   cd_i,
  output logic                             valid_o,
  output logic signed [gca_pkg::VecW-1:0]  num_o,
  output logic signed [gca_pkg::VecW-1:0]  den_o
);

  localparam int unsigned XW = gca_pkg::ScW;
  localparam int unsigned PW = 2 * XW;
  localparam int unsigned VW = gca_pkg::VecW;

  logic [2:0]           v_q;
  logic signed [PW-1:0] p1_q, p2_q, p3_q, p2b_q, p3b_q;
  logic signed [XW-1:0] cx_q;
  logic signed [PW:0]   t_q;
  logic signed [VW-1:0] num_q, den_q;

  logic signed [PW-1:0] p1_sh;
  logic signed [PW+1:0] diff;

  assign p1_sh = p1_q >>> 30;
  assign diff  = (PW+2)'(t_q) - (PW+2)'(p2b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  // Stage 1: first-level products
  always_ff @(posedge clk_i) begin
    p1_q <= s0_i * cd_i;
    p2_q <= c0_i * sx_i;
    p3_q <= sd_i * cx_i;
    cx_q <= cx_i;
  end

  // Stage 2: sin(lat1) cos(dl) scaled back, times cos(lat2)
  always_ff @(posedge clk_i) begin
    t_q   <= (PW+1)'($signed(p1_sh[34:0]) * cx_q);
    p2b_q <= p2_q;
    p3b_q <= p3_q;
  end

  // Stage 3: difference and floor shift to Q.40
  always_ff @(posedge clk_i) begin
    num_q <= VW'(diff >>> 20);
    den_q <= VW'(p3b_q >>> 20);
  end

  assign valid_o = v_q[2];
  assign num_o   = num_q;
  assign den_o   = den_q;

endmodule

>>> rtl/gca_atan2.sv
// Pipelined vectoring CORDIC atan2, final wrap and rounding to the output format.
// Depends on gca_pkg.
module gca_atan2 #(
  parameter int unsigned ANGLE_FRAC_BITS = 28,
  parameter int unsigned CORDIC_STAGES   = 28
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  logic signed [gca_pkg::VecW-1:0]  y_i,
  input  logic signed [gca_pkg::VecW-1:0]  x_i,
  output logic                             valid_o,
  output logic signed [30:0]               angle_o
);

  localparam int unsigned AW = gca_pkg::AngW;
  localparam int unsigned VW = gca_pkg::VecW;
  localparam int unsigned N  = CORDIC_STAGES;
  localparam int unsigned SH = 32 - ANGLE_FRAC_BITS;
  localparam logic signed [AW-1:0] Half = AW'(1) <<< (SH - 1);

  logic                 v_q [0:N];
  logic                 zr_q[0:N];
  logic signed [VW-1:0] x_q [0:N];
  logic signed [VW-1:0] y_q [0:N];
  logic signed [AW-1:0] z_q [0:N];

  // Entry: zero-vector flag and half-plane fold
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    zr_q[0] <= (x_i == '0) && (y_i == '0);
    if (x_i[VW-1]) begin
      x_q[0] <= -x_i;
      y_q[0] <= -y_i;
      z_q[0] <= y_i[VW-1] ? -gca_pkg::PiQ32 : gca_pkg::PiQ32;
    end else begin
      x_q[0] <= x_i;
      y_q[0] <= y_i;
      z_q[0] <= '0;
    end
  end

  // One vectoring step per stage
  for (genvar i = 0; i < N; i++) begin : g_vec
    localparam logic signed [AW-1:0] At = gca_pkg::atan_q32(i);
    logic signed [VW-1:0] dx, dy;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      zr_q[i+1] <= zr_q[i];
      if (y_q[i][VW-1]) begin
        x_q[i+1] <= x_q[i] - dx;
        y_q[i+1] <= y_q[i] + dy;
        z_q[i+1] <= z_q[i] - At;
      end else begin
        x_q[i+1] <= x_q[i] + dx;
        y_q[i+1] <= y_q[i] - dy;
        z_q[i+1] <= z_q[i] + At;
      end
    end
  end

  // Wrap into [-pi, pi]; zero vector gives zero
  logic                 vw_q, vo_q;
  logic signed [AW-1:0] zw_d, zw_q;
  logic signed [AW-1:0] zr_sum;
  logic signed [30:0]   a_q;

  always_comb begin
    zw_d = z_q[N];
    if (zr_q[N]) begin
      zw_d = '0;
    end else if (z_q[N] > gca_pkg::PiQ32) begin
      zw_d = z_q[N] - gca_pkg::TwoPiQ32;
    end else if (z_q[N] < -gca_pkg::PiQ32) begin
      zw_d = z_q[N] + gca_pkg::TwoPiQ32;
    end
  end

  assign zr_sum = zw_q + Half;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vw_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      vw_q <= v_q[N];
      vo_q <= vw_q;
    end
  end

  // Round half up to the output fraction
  always_ff @(posedge clk_i) begin
    zw_q <= zw_d;
    a_q  <= 31'(zr_sum >>> SH);
  end

  assign valid_o = vo_q;
  assign angle_o = a_q;

endmodule

>>> tb/tb.sv
// Self-checking testbench for great_circle_azimuth_core.
// Depends on the RTL top level only; the bearing predictor below is a
// bit-exact fixed-point CORDIC model written in the testbench.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LimitCycles = 400000;
  localparam int unsigned DrainCycles = 120;
  localparam int unsigned RandItems   = 1850;

  localparam longint PiQ     = 64'sd13493037705;
  localparam longint HalfPiQ = 64'sd6746518852;
  localparam longint TwoPiQ  = 64'sd26986075410;
  localparam longint GainQ   = 64'sd652032874;
  localparam int     Stages  = 28;
  localparam int     FracSh  = 4;

  // atan(2^-i), Q.32
  localparam longint AtanQ [32] = '{
    64'sd3373259426, 1991351318, 1052175346, 534100635, 268086748, 134174063,
    67103403, 33553749, 16777131, 8388597, 4194303, 2097152, 1048576,
    524288, 262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024,
    512, 256, 128, 64, 32, 16, 8, 4, 2};

  typedef struct packed {
    logic [29:0] from_lat;
    logic [29:0] to_lat;
    logic [30:0] from_lon;
    logic [30:0] to_lon;
  } pair_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic signed [29:0] from_lat_i;
  logic signed [29:0] to_lat_i;
  logic signed [30:0] from_lon_i;
  logic signed [30:0] to_lon_i;
  logic               done_o;
  logic signed [30:0] bearing_o;

  pair_t       pair_q[$];
  logic [30:0] bearing_q[$];
  int unsigned sent;
  int unsigned cycles;
  int unsigned errors;
  bit          drained_once;

  great_circle_azimuth_core uut (
    .clk_i, .rst_ni, .start_i, .busy_o,
    .from_lat_i, .to_lat_i, .from_lon_i, .to_lon_i,
    .done_o, .bearing_o
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Rotation CORDIC: angle Q.32 in (-pi, pi] to cos/sin Q.30
  function automatic void rotate(input longint a, output longint c, output longint s);
    longint x, y, z, dx, dy;
    bit     flip;
    x = GainQ;
    y = 0;
    z = a;
    flip = 1'b0;
    if (z > HalfPiQ) begin
      z -= PiQ;
      flip = 1'b1;
    end else if (z < -HalfPiQ) begin
      z += PiQ;
      flip = 1'b1;
    end
    for (int i = 0; i < Stages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanQ[i];
      end else begin
        x += dx; y -= dy; z += AtanQ[i];
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Vectoring CORDIC: atan2(y, x) in Q.32
  function automatic longint vector_angle(input longint yi, input longint xi);
    longint x, y, z, dx, dy;
    x = xi;
    y = yi;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? PiQ : -PiQ;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < Stages; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; z -= AtanQ[i];
      end else begin
        x += dx; y -= dy; z += AtanQ[i];
      end
    end
    return z;
  endfunction

  // Latitude to Q.32, clamped one LSB inside the poles
  function automatic longint clamp_lat(input logic [29:0] raw);
    longint v, lim;
    lim = HalfPiQ - (64'sd1 <<< FracSh);
    v = longint'($signed(raw)) * 16;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v;
  endfunction

  function automatic logic [30:0] predict_bearing(input pair_t p);
    longint la0, la1, dl, s0, c0, s1, c1, sd, cd, num, den, z, r;
    la0 = clamp_lat(p.from_lat);
    la1 = clamp_lat(p.to_lat);
    dl = (longint'($signed(p.from_lon)) - longint'($signed(p.to_lon))) * 16;
    dl = dl % TwoPiQ;
    if (dl > PiQ) dl -= TwoPiQ;
    if (dl <= -PiQ) dl += TwoPiQ;
    rotate(la0, c0, s0);
    rotate(la1, c1, s1);
    rotate(dl, cd, sd);
    num = ((s0 * cd) >>> 30) * c1 - c0 * s1;
    den = sd * c1;
    z = vector_angle(den >>> 20, num >>> 20);
    if (z > PiQ) z -= TwoPiQ;
    if (z < -PiQ) z += TwoPiQ;
    r = (z + (64'sd1 <<< (FracSh - 1))) >>> FracSh;
    return r[30:0];
  endfunction

  function automatic pair_t mk(input longint a, input longint b, input longint c,
                               input longint d);
    pair_t p;
    p.from_lat = a[29:0];
    p.to_lat   = b[29:0];
    p.from_lon = c[30:0];
    p.to_lon   = d[30:0];
    return p;
  endfunction

  function automatic longint rand_lat();
    case ($urandom_range(0, 9))
      0: return longint'($signed(30'($urandom)));
      1: return ($urandom_range(0, 1) ? 421657428 : -421657428) - $urandom_range(0, 3);
      default: return longint'($urandom_range(0, 843314856)) - 421657428;
    endcase
  endfunction

  function automatic longint rand_lon();
    if ($urandom_range(0, 4) == 0) return longint'($signed(31'($urandom)));
    return longint'($urandom_range(0, 1686629714)) - 843314857;
  endfunction

  // Stimulus: directed corner cases, then random pairs
  initial begin
    longint a, b, c;
    rst_ni = 1'b0;
    pair_q.push_back(mk(0, 0, 0, 0));
    pair_q.push_back(mk(421657428, 421657428, 0, 0));
    pair_q.push_back(mk(-421657428, -421657428, 0, 0));
    pair_q.push_back(mk(421657428, -421657428, 843314857, -843314857));
    pair_q.push_back(mk(-421657428, 421657428, -843314857, 843314857));
    pair_q.push_back(mk(536870911, -536870912, 0, 100));
    pair_q.push_back(mk(-536870912, 536870911, 1073741823, -1073741824));
    pair_q.push_back(mk(0, 0, 1000, 0));
    pair_q.push_back(mk(0, 0, -1000, 0));
    pair_q.push_back(mk(0, 100000000, 0, 0));
    pair_q.push_back(mk(100000000, 0, 0, 0));
    pair_q.push_back(mk(0, 0, 843314857, 0));
    pair_q.push_back(mk(0, 0, -843314857, 0));
    pair_q.push_back(mk(0, 0, 843314857, -843314857));
    pair_q.push_back(mk(200000000, 200000000, 300000000, 300000000));
    pair_q.push_back(mk(-300000000, 100000000, -500000000, 400000000));
    pair_q.push_back(mk(300000000, -100000000, 700000000, -600000000));
    pair_q.push_back(mk(421657427, 0, 1, -1));
    pair_q.push_back(mk(1, -1, 0, 0));
    pair_q.push_back(mk(-1, 1, 1, 0));
    for (int n = 0; n < RandItems; n++) begin
      a = rand_lat();
      c = rand_lon();
      b = ($urandom_range(0, 19) == 0) ? a : rand_lat();
      pair_q.push_back(mk(a, b, c, ($urandom_range(0, 19) == 0) ? c : rand_lon()));
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pair_q.size() == 0 && !start_i);
    wait (bearing_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Driver: random gaps, a gap-free stretch, and one full drain pause
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_i      <= 1'b0;
      from_lat_i   <= '0;
      to_lat_i     <= '0;
      from_lon_i   <= '0;
      to_lon_i     <= '0;
      sent         <= 0;
      drained_once <= 1'b0;
    end else if (!(start_i && busy_o)) begin
      if (sent == 900 && !drained_once) begin
        start_i <= 1'b0;
        if (bearing_q.size() == 0 && !start_i) drained_once <= 1'b1;
      end else if (pair_q.size() > 0 &&
                   ((sent >= 300 && sent < 700) || $urandom_range(0, 99) >= 22)) begin
        start_i    <= 1'b1;
        from_lat_i <= pair_q[0].from_lat;
        to_lat_i   <= pair_q[0].to_lat;
        from_lon_i <= pair_q[0].from_lon;
        to_lon_i   <= pair_q[0].to_lon;
        void'(pair_q.pop_front());
        sent       <= sent + 1;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: record each accepted transfer, check each result against the oldest
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (bearing_q.size() == 0) begin
          $error("unexpected bearing result %0d", bearing_o);
          errors++;
        end else begin
          if (bearing_o !== bearing_q[0]) begin
            $error("bearing: expected %0d, actual %0d",
                   $signed(bearing_q[0]), bearing_o);
            errors++;
          end
          void'(bearing_q.pop_front());
        end
      end
      if (start_i && !busy_o)
        bearing_q.push_back(predict_bearing({from_lat_i, to_lat_i, from_lon_i, to_lon_i}));
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial cycles = 0;
  initial errors = 0;

endmodule
